// File: sv/meter_teleinfo_frame_parser_top_assert.svh
// Assertion macros shared by the frame parser RTL.
// No dependencies; included by the files that check their own logic.
`ifndef METER_TELEINFO_FRAME_PARSER_TOP_ASSERT_SVH
`define METER_TELEINFO_FRAME_PARSER_TOP_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication.
`define MTFP_ASSERT_IMPLY(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("mtfp assertion failed");

// Next-cycle implication.
`define MTFP_ASSERT_NEXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("mtfp assertion failed");

`else

`define MTFP_ASSERT_IMPLY(lbl, ck, rs, ante, cons)
`define MTFP_ASSERT_NEXT(lbl, ck, rs, ante, cons)

`endif

`endif

// File: sv/mtfp_pkg.sv
// Types and character codes for the meter frame parser.
// No dependencies; used by the store, the sequencer and the top level.
package mtfp_pkg;

  typedef logic [6:0] char_t;

  localparam char_t CH_STX   = 7'h02;
  localparam char_t CH_ETX   = 7'h03;
  localparam char_t CH_TAB   = 7'h09;
  localparam char_t CH_LF    = 7'h0A;
  localparam char_t CH_CR    = 7'h0D;
  localparam char_t CH_SPACE = 7'h20;
  localparam char_t CHK_BIAS = 7'h20;

  localparam int NAME_W  = 64;
  localparam int VALUE_W = 96;
  localparam int LEN_W   = 4;

  // message-end scan request from the byte front end
  typedef struct packed {
    logic start;
    logic historic;
  } scan_req_t;

  // scan outcome, valid while done is high
  typedef struct packed {
    logic               done;
    logic               status;
    logic [NAME_W-1:0]  name_text;
    logic [LEN_W-1:0]   name_length;
    logic [VALUE_W-1:0] value_text;
    logic [LEN_W-1:0]   value_length;
  } scan_res_t;

endpackage

// File: sv/mtfp_if.sv
// Valid/ready channel interfaces for the meter frame parser.
// No dependencies; used by the top level ports.
interface mtfp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface mtfp_result_if;
  logic        valid;
  logic        ready;
  logic        status;
  logic [63:0] name_text;
  logic [3:0]  name_length;
  logic [63:0] value_text_low;
  logic [31:0] value_text_high;
  logic [3:0]  value_length;

  modport source (output valid, output status, output name_text, output name_length,
                  output value_text_low, output value_text_high, output value_length,
                  input ready);
  modport sink (input valid, input status, input name_text, input name_length,
                input value_text_low, input value_text_high, input value_length,
                output ready);
endinterface

// File: sv/mtfp_store.sv
// Message byte store: one write port, one registered read port.
// Depends on mtfp_pkg for the character type.
module mtfp_store #(
  parameter int DEPTH = 37,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic                clk,
  input  logic                wr_en,
  input  logic [ADDR_W-1:0]   wr_addr,
  input  mtfp_pkg::char_t     wr_data,
  input  logic                rd_en,
  input  logic [ADDR_W-1:0]   rd_addr,
  output mtfp_pkg::char_t     rd_data
);
  import mtfp_pkg::*;

  char_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: sv/mtfp_scan.sv
// Message-end sequencer: walks the byte store through one read port,
// sums the checksum, locates separators and gathers name and value text.
// Depends on mtfp_pkg and the assertion macro header.
`include "meter_teleinfo_frame_parser_top_assert.svh"

module mtfp_scan #(
  parameter int MESSAGE_BYTES = 37,
  parameter int TAG_BYTES = 8,
  parameter int VALUE_BYTES = 12,
  localparam int FILL_W = $clog2(MESSAGE_BYTES + 1),
  localparam int ADDR_W = $clog2(MESSAGE_BYTES)
) (
  input  logic                clk,
  input  logic                rst,
  input  mtfp_pkg::scan_req_t req,
  input  logic [FILL_W-1:0]   fill,
  output logic                rd_en,
  output logic [ADDR_W-1:0]   rd_addr,
  input  mtfp_pkg::char_t     rd_data,
  output logic                busy,
  output mtfp_pkg::scan_res_t res
);
  import mtfp_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_PASS  = 3'd1;
  localparam logic [2:0] S_CHECK = 3'd2;
  localparam logic [2:0] S_VALUE = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [2:0]         state;
  logic [FILL_W-1:0]  n_last;
  logic [FILL_W-1:0]  span;
  char_t              sep;
  logic [FILL_W-1:0]  iss;
  logic               pv;
  logic [FILL_W-1:0]  p_idx;
  logic [5:0]         sum;
  logic [2:0]         cnt;
  logic [ADDR_W-1:0]  pos0;
  logic [ADDR_W-1:0]  pos1;
  logic [ADDR_W-1:0]  pos2;
  char_t              chk;
  logic               err;
  logic [NAME_W-1:0]  name_text;
  logic               name_zero;
  logic [LEN_W-1:0]   name_len;
  logic [ADDR_W-1:0]  vbase;
  logic [LEN_W-1:0]   vlen;
  logic [LEN_W-1:0]   vis;
  logic [VALUE_W-1:0] value_text;
  logic               val_zero;

  // checksum and separator verdict, value field bounds
  logic               ok_sum;
  logic               ok_cnt;
  logic [ADDR_W-1:0]  vs;
  logic [ADDR_W-1:0]  ve;
  logic [ADDR_W-1:0]  vdiff;
  logic [LEN_W-1:0]   vl;
  logic [LEN_W-1:0]   nl;

  always_comb begin
    ok_sum = (chk == (char_t'(sum) + CHK_BIAS));
    ok_cnt = (cnt == 3'd2) || (cnt == 3'd3);
    vs     = ((cnt == 3'd2) ? pos0 : pos1) + 1'b1;
    ve     = (cnt == 3'd2) ? pos1 : pos2;
    vdiff  = ve - vs;
    vl     = (vdiff < VALUE_BYTES) ? LEN_W'(vdiff) : LEN_W'(VALUE_BYTES);
    nl     = (pos0 < TAG_BYTES) ? LEN_W'(pos0) : LEN_W'(TAG_BYTES);
  end

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = iss[ADDR_W-1:0];
    unique case (state)
      S_PASS: begin
        rd_en = (iss <= n_last);
      end
      S_VALUE: begin
        rd_en   = (vis < vlen);
        rd_addr = vbase + ADDR_W'(vis);
      end
      default: begin
        rd_en = 1'b0;
      end
    endcase
  end

  assign busy = (state != S_IDLE);

  always_comb begin
    res              = '0;
    res.done         = (state == S_DONE);
    res.status       = err;
    if (!err) begin
      res.name_text    = name_text;
      res.name_length  = name_len;
      res.value_text   = value_text;
      res.value_length = vlen;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      pv    <= 1'b0;
      err   <= 1'b0;
    end else begin
      pv    <= rd_en;
      p_idx <= (state == S_PASS) ? iss : FILL_W'(vis);
      if (rd_en && (state == S_PASS)) begin
        iss <= iss + 1'b1;
      end
      if (rd_en && (state == S_VALUE)) begin
        vis <= vis + 1'b1;
      end
      unique case (state)
        S_IDLE: begin
          if (req.start) begin
            err       <= 1'b0;
            n_last    <= fill - 1'b1;
            span      <= req.historic ? (fill - 2'd2) : (fill - 1'b1);
            sep       <= req.historic ? CH_SPACE : CH_TAB;
            iss       <= '0;
            sum       <= '0;
            cnt       <= '0;
            pos0      <= '0;
            pos1      <= '0;
            pos2      <= '0;
            name_text <= '0;
            name_zero <= 1'b0;
            if (fill < 2) begin
              err   <= 1'b1;
              state <= S_DONE;
            end else begin
              state <= S_PASS;
            end
          end
        end
        S_PASS: begin
          if (pv) begin
            if (p_idx < span) begin
              sum <= sum + rd_data[5:0];
            end
            if (p_idx == n_last) begin
              chk   <= rd_data;
              state <= S_CHECK;
            end else if (rd_data == sep) begin
              if (cnt == 3'd0) pos0 <= p_idx[ADDR_W-1:0];
              if (cnt == 3'd1) pos1 <= p_idx[ADDR_W-1:0];
              if (cnt == 3'd2) pos2 <= p_idx[ADDR_W-1:0];
              // saturate past three; only two or three pass the check
              if (cnt != 3'd4) cnt <= cnt + 1'b1;
            end else if ((cnt == 3'd0) && (p_idx < TAG_BYTES)) begin
              // a zero character blanks the rest of the name
              if (rd_data == '0) begin
                name_zero <= 1'b1;
              end else if (!name_zero) begin
                name_text[{p_idx[2:0], 3'b000} +: 8] <= {1'b0, rd_data};
              end
            end
          end
        end
        S_CHECK: begin
          name_len   <= nl;
          vbase      <= vs;
          vlen       <= vl;
          vis        <= '0;
          value_text <= '0;
          val_zero   <= 1'b0;
          if (!ok_sum || !ok_cnt) begin
            err   <= 1'b1;
            state <= S_DONE;
          end else if (vl == '0) begin
            state <= S_DONE;
          end else begin
            state <= S_VALUE;
          end
        end
        S_VALUE: begin
          if (pv) begin
            if (rd_data == '0) begin
              val_zero <= 1'b1;
            end else if (!val_zero) begin
              value_text[{p_idx[3:0], 3'b000} +: 8] <= {1'b0, rd_data};
            end
            if (p_idx[LEN_W-1:0] == (vlen - 1'b1)) begin
              state <= S_DONE;
            end
          end
        end
        S_DONE: begin
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `MTFP_ASSERT_IMPLY(a_start_idle, clk, rst, req.start, state == S_IDLE)
  `MTFP_ASSERT_IMPLY(a_ok_lengths, clk, rst, res.done && !res.status,
                     (res.name_length <= TAG_BYTES) && (res.value_length <= VALUE_BYTES))
  `MTFP_ASSERT_IMPLY(a_read_range, clk, rst, rd_en, rd_addr < MESSAGE_BYTES)

endmodule

// File: sv/meter_teleinfo_frame_parser_top.sv
// Meter tele-information frame parser. Each request carries one received byte; it is
// checked for even parity, stripped to 7 bits and tracked through STX/ETX frames and
// LF..CR messages. Ordinary bytes are taken one per cycle. At CR the block stops taking
// requests while one sequencer walks the message store through its single read port:
// first the stored bytes (up to MESSAGE_BYTES), then the delivered value bytes; that
// walk sets the rate. A result waits in an output register; a new byte is taken as
// soon as that register is free or being read. No clearing pass is needed after
// reset. Depends on mtfp_pkg, mtfp_if, mtfp_store and mtfp_scan.
`include "meter_teleinfo_frame_parser_top_assert.svh"

module meter_teleinfo_frame_parser_top #(
  parameter int MESSAGE_BYTES = 37,
  parameter int TAG_BYTES = 8,
  parameter int VALUE_BYTES = 12
) (
  input logic           clk,
  input logic           rst,
  mtfp_byte_if.sink     rx,
  mtfp_result_if.source res
);
  import mtfp_pkg::*;

  localparam int FILL_W = $clog2(MESSAGE_BYTES + 1);
  localparam int ADDR_W = $clog2(MESSAGE_BYTES);

  localparam logic [1:0] PH_FRAME = 2'd0;
  localparam logic [1:0] PH_LINE  = 2'd1;
  localparam logic [1:0] PH_TAG   = 2'd2;
  localparam logic [1:0] PH_BODY  = 2'd3;

  logic [1:0]        phase;
  logic [1:0]        phase_next;
  logic [FILL_W-1:0] fill;
  logic [FILL_W-1:0] fill_next;
  logic              historic;
  logic              historic_next;

  logic              accept;
  logic              byte_err;
  logic              wr_en;
  char_t             c;
  scan_req_t         scan_req;
  scan_res_t         scan_res;
  logic              scan_busy;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  char_t             rd_data;

  logic              out_valid;
  logic              out_status;
  logic [63:0]       out_name;
  logic [3:0]        out_name_len;
  logic [95:0]       out_value;
  logic [3:0]        out_value_len;

  assign rx.ready = !scan_busy && (!out_valid || res.ready);
  assign accept   = rx.valid && rx.ready;
  assign c        = rx.rx_byte[6:0];

  always_comb begin
    phase_next        = phase;
    fill_next         = fill;
    historic_next     = historic;
    wr_en             = 1'b0;
    byte_err          = 1'b0;
    scan_req.start    = 1'b0;
    scan_req.historic = historic;
    if (accept) begin
      if (^rx.rx_byte) begin
        byte_err   = 1'b1;
        phase_next = PH_FRAME;
      end else begin
        unique case (phase)
          PH_FRAME: begin
            if (c == CH_STX) phase_next = PH_LINE;
          end
          PH_LINE: begin
            if (c == CH_LF) begin
              fill_next  = '0;
              phase_next = PH_TAG;
            end else if (c == CH_ETX) begin
              phase_next = PH_FRAME;
            end else begin
              byte_err   = 1'b1;
              phase_next = PH_FRAME;
            end
          end
          PH_TAG: begin
            if ((c == CH_TAB) || (c == CH_SPACE)) begin
              if (fill >= MESSAGE_BYTES) begin
                byte_err   = 1'b1;
                phase_next = PH_FRAME;
              end else begin
                wr_en         = 1'b1;
                fill_next     = fill + 1'b1;
                historic_next = (c == CH_SPACE);
                phase_next    = PH_BODY;
              end
            end else if ((fill >= TAG_BYTES) || (fill >= MESSAGE_BYTES)) begin
              byte_err   = 1'b1;
              phase_next = PH_FRAME;
            end else begin
              wr_en     = 1'b1;
              fill_next = fill + 1'b1;
            end
          end
          PH_BODY: begin
            if (c == CH_CR) begin
              scan_req.start = 1'b1;
            end else if (fill >= MESSAGE_BYTES) begin
              // store full: drop the byte and wait for the next frame
              phase_next = PH_FRAME;
            end else begin
              wr_en     = 1'b1;
              fill_next = fill + 1'b1;
            end
          end
          default: begin
            phase_next = PH_FRAME;
          end
        endcase
      end
    end
    if (scan_res.done) begin
      phase_next = scan_res.status ? PH_FRAME : PH_LINE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_FRAME;
      fill      <= '0;
      historic  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      phase    <= phase_next;
      fill     <= fill_next;
      historic <= historic_next;
      if (byte_err) begin
        out_valid     <= 1'b1;
        out_status    <= 1'b1;
        out_name      <= '0;
        out_name_len  <= '0;
        out_value     <= '0;
        out_value_len <= '0;
      end else if (scan_res.done) begin
        out_valid     <= 1'b1;
        out_status    <= scan_res.status;
        out_name      <= scan_res.name_text;
        out_name_len  <= scan_res.name_length;
        out_value     <= scan_res.value_text;
        out_value_len <= scan_res.value_length;
      end else if (res.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign res.valid           = out_valid;
  assign res.status          = out_status;
  assign res.name_text       = out_name;
  assign res.name_length     = out_name_len;
  assign res.value_text_low  = out_value[63:0];
  assign res.value_text_high = out_value[95:64];
  assign res.value_length    = out_value_len;

  mtfp_store #(
    .DEPTH(MESSAGE_BYTES)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (fill[ADDR_W-1:0]),
    .wr_data (c),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  mtfp_scan #(
    .MESSAGE_BYTES(MESSAGE_BYTES),
    .TAG_BYTES(TAG_BYTES),
    .VALUE_BYTES(VALUE_BYTES)
  ) u_scan (
    .clk     (clk),
    .rst     (rst),
    .req     (scan_req),
    .fill    (fill),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .busy    (scan_busy),
    .res     (scan_res)
  );

  `MTFP_ASSERT_IMPLY(a_done_slot_free, clk, rst, scan_res.done, !out_valid)
  `MTFP_ASSERT_IMPLY(a_tag_fill, clk, rst, phase == PH_TAG, fill <= TAG_BYTES)
  `MTFP_ASSERT_NEXT(a_cr_starts_scan, clk, rst, scan_req.start, scan_busy)

endmodule
